// File: src/oat_pkg.sv
// shared types and codes for the ordered array table
package oat_pkg;

	// fixed field widths
	localparam int unsigned POS_W    = 10;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 11;

	// operation codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// position modes for insert and remove; the fourth code is unused
	localparam logic [1:0] MODE_INDEX = 2'd0;
	localparam logic [1:0] MODE_FRONT = 2'd1;
	localparam logic [1:0] MODE_BACK  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_INS_WRITE,
		S_SHIFT_DN,
		S_SEARCH,
		S_READ_WAIT,
		S_FINISH
	} state_t;

endpackage

// File: src/oat_ram.sv
// generic single-write, single-read ram with registered read data
module oat_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/ordered_array_table_core.sv
// ordered array table: sequencer around one entry ram
// Keeps up to CAPACITY signed 32-bit entries in order in one ram with a registered read,
// plus a count. One transaction is handled at a time. An insert before index k moves
// count-k entries; a removal at index k moves count-k-1 entries; a find walks up to
// count entries. The ram does one read and one write per cycle, so a shift moves one
// entry per cycle and a search compares one entry per cycle. The ram needs no clearing
// after reset, since only entries below the count are ever used. A finished result
// sits in an output register until taken.
module ordered_array_table_core #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [1:0]                         operation,
	input  logic [1:0]                         position_mode,
	input  logic [oat_pkg::POS_W-1:0]          position,
	input  logic signed [oat_pkg::VAL_W-1:0]   item_value,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [oat_pkg::STATUS_W-1:0]       status,
	output logic [oat_pkg::POS_W-1:0]          found_position,
	output logic signed [oat_pkg::VAL_W-1:0]   read_value,
	output logic [oat_pkg::COUNT_W-1:0]        entry_count
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned WW = (CW > oat_pkg::COUNT_W) ? CW : oat_pkg::COUNT_W;

	oat_pkg::state_t state_q, state_d;

	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  ptr_q;
	logic [AW-1:0]                  at_q;
	logic [oat_pkg::VAL_W-1:0]      val_q;
	logic [oat_pkg::STATUS_W-1:0]   res_status_q;
	logic [AW-1:0]                  res_found_q;
	logic [oat_pkg::VAL_W-1:0]      res_value_q;
	logic                           result_valid_q;
	logic [oat_pkg::STATUS_W-1:0]   status_q;
	logic [oat_pkg::POS_W-1:0]      found_position_q;
	logic [oat_pkg::VAL_W-1:0]      read_value_q;
	logic [oat_pkg::COUNT_W-1:0]    entry_count_q;

	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [oat_pkg::VAL_W-1:0]      mem_wdata;
	logic [AW-1:0]                  mem_raddr;
	logic [oat_pkg::VAL_W-1:0]      mem_rdata;

	logic                           accept;
	logic                           out_free;
	oat_pkg::op_t                   op;
	logic [WW-1:0]                  fill_w;
	logic [WW-1:0]                  pos_w;
	logic [WW-1:0]                  ptr_w;
	logic [oat_pkg::STATUS_W-1:0]   ins_status;
	logic [WW-1:0]                  ins_at_w;
	logic                           ins_shift;
	logic [oat_pkg::STATUS_W-1:0]   rem_status;
	logic [WW-1:0]                  rem_at_w;
	logic                           rem_shift;
	logic                           rd_ok;
	logic                           up_last;
	logic                           dn_last;
	logic                           search_hit;
	logic                           search_last;
	logic [WW-1:0]                  found_w;
	logic [WW-1:0]                  count_out_w;

	// entry store
	oat_ram #(
		.WIDTH(oat_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign accept   = item_valid && item_ready;
	assign out_free = !result_valid_q || result_ready;
	assign op       = oat_pkg::op_t'(operation);
	assign fill_w   = WW'(count_q);
	assign pos_w    = WW'(position);
	assign ptr_w    = WW'(ptr_q);

	// insert decode
	always_comb begin
		ins_at_w = pos_w;
		priority if (position_mode == oat_pkg::MODE_INDEX && pos_w > fill_w) begin
			ins_status = oat_pkg::ST_RANGE;
		end else if (position_mode != oat_pkg::MODE_INDEX &&
				position_mode != oat_pkg::MODE_FRONT &&
				position_mode != oat_pkg::MODE_BACK) begin
			ins_status = oat_pkg::ST_RANGE;
		end else if (fill_w >= WW'(CAPACITY)) begin
			ins_status = oat_pkg::ST_FULL;
		end else begin
			ins_status = oat_pkg::ST_OK;
		end
		if (position_mode == oat_pkg::MODE_FRONT) begin
			ins_at_w = '0;
		end else if (position_mode == oat_pkg::MODE_BACK) begin
			ins_at_w = fill_w;
		end
	end

	assign ins_shift = (ins_at_w != fill_w);

	// remove decode
	always_comb begin
		rem_at_w = pos_w;
		priority if (count_q == '0) begin
			rem_status = oat_pkg::ST_EMPTY;
		end else if (position_mode == oat_pkg::MODE_INDEX && pos_w >= fill_w) begin
			rem_status = oat_pkg::ST_RANGE;
		end else if (position_mode != oat_pkg::MODE_INDEX &&
				position_mode != oat_pkg::MODE_FRONT &&
				position_mode != oat_pkg::MODE_BACK) begin
			rem_status = oat_pkg::ST_RANGE;
		end else begin
			rem_status = oat_pkg::ST_OK;
		end
		if (position_mode == oat_pkg::MODE_FRONT) begin
			rem_at_w = '0;
		end else if (position_mode == oat_pkg::MODE_BACK) begin
			rem_at_w = fill_w - WW'(1);
		end
	end

	assign rem_shift   = (rem_at_w + WW'(1) != fill_w);
	assign rd_ok       = (pos_w < fill_w);
	assign up_last     = (ptr_q == at_q + AW'(1));
	assign dn_last     = (ptr_w + WW'(2) == fill_w);
	assign search_hit  = (mem_rdata == val_q);
	assign search_last = (ptr_w + WW'(1) == fill_w);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oat_pkg::S_IDLE: begin
				if (item_valid) begin
					unique case (op)
						oat_pkg::OP_INSERT: begin
							if (ins_status == oat_pkg::ST_OK && ins_shift) begin
								state_d = oat_pkg::S_SHIFT_UP;
							end else begin
								state_d = oat_pkg::S_FINISH;
							end
						end
						oat_pkg::OP_REMOVE: begin
							if (rem_status == oat_pkg::ST_OK && rem_shift) begin
								state_d = oat_pkg::S_SHIFT_DN;
							end else begin
								state_d = oat_pkg::S_FINISH;
							end
						end
						oat_pkg::OP_FIND: begin
							state_d = (count_q == '0) ? oat_pkg::S_FINISH : oat_pkg::S_SEARCH;
						end
						oat_pkg::OP_READ: begin
							state_d = rd_ok ? oat_pkg::S_READ_WAIT : oat_pkg::S_FINISH;
						end
						default: state_d = oat_pkg::S_FINISH;
					endcase
				end
			end
			oat_pkg::S_SHIFT_UP: begin
				if (up_last) begin
					state_d = oat_pkg::S_INS_WRITE;
				end
			end
			oat_pkg::S_INS_WRITE: state_d = oat_pkg::S_FINISH;
			oat_pkg::S_SHIFT_DN: begin
				if (dn_last) begin
					state_d = oat_pkg::S_FINISH;
				end
			end
			oat_pkg::S_SEARCH: begin
				if (search_hit || search_last) begin
					state_d = oat_pkg::S_FINISH;
				end
			end
			oat_pkg::S_READ_WAIT: state_d = oat_pkg::S_FINISH;
			oat_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = oat_pkg::S_IDLE;
				end
			end
			default: state_d = oat_pkg::S_IDLE;
		endcase
	end

	// handshake and ram control
	always_comb begin
		item_ready = (state_q == oat_pkg::S_IDLE);
		mem_we     = 1'b0;
		mem_waddr  = ptr_q;
		mem_wdata  = mem_rdata;
		mem_raddr  = ptr_q;
		unique case (state_q)
			oat_pkg::S_IDLE: begin
				unique case (op)
					oat_pkg::OP_INSERT: begin
						mem_we    = item_valid && ins_status == oat_pkg::ST_OK && !ins_shift;
						mem_waddr = ins_at_w[AW-1:0];
						mem_wdata = item_value;
						mem_raddr = AW'(fill_w - WW'(1));
					end
					oat_pkg::OP_REMOVE: mem_raddr = AW'(rem_at_w + WW'(1));
					oat_pkg::OP_FIND:   mem_raddr = '0;
					oat_pkg::OP_READ:   mem_raddr = pos_w[AW-1:0];
					default:            mem_raddr = '0;
				endcase
			end
			oat_pkg::S_SHIFT_UP: begin
				mem_we    = 1'b1;
				mem_raddr = ptr_q - AW'(2);
			end
			oat_pkg::S_INS_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = at_q;
				mem_wdata = val_q;
			end
			oat_pkg::S_SHIFT_DN: begin
				mem_we    = 1'b1;
				mem_raddr = AW'(ptr_w + WW'(2));
			end
			oat_pkg::S_SEARCH: mem_raddr = ptr_q + AW'(1);
			oat_pkg::S_READ_WAIT: mem_raddr = ptr_q;
			oat_pkg::S_FINISH: mem_raddr = ptr_q;
			default: mem_raddr = ptr_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= oat_pkg::S_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && op == oat_pkg::OP_INSERT && ins_status == oat_pkg::ST_OK &&
					!ins_shift) begin
				count_q <= count_q + CW'(1);
			end else if (accept && op == oat_pkg::OP_REMOVE &&
					rem_status == oat_pkg::ST_OK && !rem_shift) begin
				count_q <= count_q - CW'(1);
			end else if (state_q == oat_pkg::S_INS_WRITE) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == oat_pkg::S_SHIFT_DN && dn_last) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == oat_pkg::S_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			oat_pkg::S_IDLE: begin
				if (item_valid) begin
					val_q       <= item_value;
					res_found_q <= '0;
					res_value_q <= '0;
					unique case (op)
						oat_pkg::OP_INSERT: begin
							res_status_q <= ins_status;
							at_q         <= ins_at_w[AW-1:0];
							ptr_q        <= fill_w[AW-1:0];
						end
						oat_pkg::OP_REMOVE: begin
							res_status_q <= rem_status;
							ptr_q        <= rem_at_w[AW-1:0];
						end
						oat_pkg::OP_FIND: begin
							res_status_q <= oat_pkg::ST_NOTFOUND;
							ptr_q        <= '0;
						end
						oat_pkg::OP_READ: begin
							res_status_q <= rd_ok ? oat_pkg::ST_OK : oat_pkg::ST_RANGE;
						end
						default: res_status_q <= oat_pkg::ST_RANGE;
					endcase
				end
			end
			oat_pkg::S_SHIFT_UP: ptr_q <= ptr_q - AW'(1);
			oat_pkg::S_SHIFT_DN: ptr_q <= ptr_q + AW'(1);
			oat_pkg::S_SEARCH: begin
				if (search_hit) begin
					res_status_q <= oat_pkg::ST_OK;
					res_found_q  <= ptr_q;
				end
				ptr_q <= ptr_q + AW'(1);
			end
			oat_pkg::S_READ_WAIT: res_value_q <= mem_rdata;
			oat_pkg::S_INS_WRITE: ;
			oat_pkg::S_FINISH: begin
				if (out_free) begin
					status_q         <= res_status_q;
					found_position_q <= found_w[oat_pkg::POS_W-1:0];
					read_value_q     <= res_value_q;
					entry_count_q    <= count_out_w[oat_pkg::COUNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign found_w     = WW'(res_found_q);
	assign count_out_w = WW'(count_q);

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign found_position = found_position_q;
	assign read_value     = read_value_q;
	assign entry_count    = entry_count_q;

`ifndef NO_ASSERTIONS
	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(count_q) <= WW'(CAPACITY))
		else $error("entry count above capacity");

	// a transaction is taken only while no other one is in work
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("item taken while busy");

	// a result appears only out of the finishing step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == oat_pkg::S_FINISH))
		else $error("result without finishing step");

	// the ram is never written while searching, reading or finishing
	a_no_stray_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != oat_pkg::S_SEARCH && state_q != oat_pkg::S_READ_WAIT &&
			state_q != oat_pkg::S_FINISH))
		else $error("unexpected ram write");
`endif

endmodule
